>>> rtl/rsr_pkg.sv
// shared types and constants for the reliable stream receiver
package rsr_pkg;

   localparam int MaxIntervals = 16;
   localparam int IdxW = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
   localparam int CntW = $clog2(MaxIntervals + 1);

   localparam logic [7:0]  FRAME_MAGIC = 8'h45;
   localparam int          KIND_DATA_BIT = 0;
   localparam logic [17:0] IDLE_MAX = 18'h3FFFF;

   localparam logic [1:0] CSR_TOTAL_LENGTH = 2'd0;
   localparam logic [1:0] CSR_WINDOW_SIZE  = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT      = 2'd2;

   localparam logic [1:0] REPLY_NONE   = 2'd0;
   localparam logic [1:0] REPLY_ACK    = 2'd1;
   localparam logic [1:0] REPLY_RESEND = 2'd2;

   localparam logic [1:0] STATUS_RUN  = 2'd0;
   localparam logic [1:0] STATUS_DONE = 2'd1;
   localparam logic [1:0] STATUS_FAIL = 2'd2;

   // classified item passed from the front end to the engine
   typedef struct packed {
      logic        idle;
      logic        data;
      logic        len_ok;
      logic [31:0] seq;
      logic [31:0] seg_end;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  reply_kind;
      logic [31:0] reply_seq;
      logic        accepted;
      logic [31:0] copy_start;
      logic [31:0] copy_end;
      logic [1:0]  status;
      logic [31:0] received_count;
   } rsp_type;

endpackage

>>> rtl/rsr_front.sv
// front end: takes request items, classifies them and queues them for the engine
module rsr_front import rsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_magic,
   input  logic [7:0]  req_kind_bits,
   input  logic [15:0] req_seg_length,
   input  logic [31:0] req_seg_seq,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output cmd_type     cmd
);

   // two-entry queue
   cmd_type    q_ff [2];
   cmd_type    q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    cls;
   logic [32:0] sum;
   logic push, pop;

   assign sum = {1'b0, req_seg_seq} + {17'd0, req_seg_length};
   always_comb begin
      cls.idle    = req_mode;
      cls.data    = (req_magic == FRAME_MAGIC) && req_kind_bits[KIND_DATA_BIT];
      cls.len_ok  = !sum[32] && (req_seg_length != 16'd0);
      cls.seq     = req_seg_seq;
      cls.seg_end = sum[31:0];
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop = cmd_valid && cmd_ready;
   assign cmd = q_ff[0];

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = cls;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_max: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count overflow");
   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !pop) |=> cnt_ff == 2'd2)
      else $error("queue lost an entry");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 2'd1)
      else $error("push not counted");

endmodule

>>> rtl/rsr_engine.sv
// engine: interval table search, merge and shift, reply generation
module rsr_engine import rsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [30:0] total_length,
   input  logic [15:0] window_size,
   input  logic [15:0] timeout_ticks,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   output logic        out_valid,
   input  logic        out_ready,
   output rsp_type     out_rsp
);

   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;

   logic [1:0]  state_ff, state_in;
   cmd_type     c_ff, c_in;
   logic [31:0] istart_ff [MaxIntervals];
   logic [31:0] iend_ff   [MaxIntervals];
   logic [31:0] istart_in [MaxIntervals];
   logic [31:0] iend_in   [MaxIntervals];
   logic [CntW-1:0] count_ff, count_in;
   logic [31:0] cont_ff, cont_in, high_ff, high_in;
   logic [17:0] idle_ff, idle_in;
   logic        started_ff, started_in;
   logic        ov_ff, ov_in;
   rsp_type     rsp_ff, rsp_in;
   // per-cell compare results, registered in the load step
   logic [MaxIntervals-1:0] le_ff, le_in;

   logic        have_p;
   logic [IdxW-1:0] p;
   logic [CntW-1:0] p1;
   logic [31:0] pend, nstart, nend, newend, cs, ce;
   logic        has_next, rej, full, touch;
   logic [32:0] win;
   logic [18:0] two_to;

   always_comb begin
      for (int i = 0; i < MaxIntervals; i++) begin
         le_in[i] = (CntW'(i) < count_ff) && (istart_ff[i] <= cmd.seq);
      end
   end

   // sorted table: le bits form a prefix, p is the last set bit
   always_comb begin
      have_p = 1'b0;
      p = '0;
      for (int i = 0; i < MaxIntervals; i++) begin
         if (le_ff[i]) begin
            have_p = 1'b1;
            p = IdxW'(i);
         end
      end
      p1 = have_p ? CntW'(p) + CntW'(1) : '0;
      pend = have_p ? iend_ff[p] : cont_ff;
      has_next = p1 < count_ff;
      nstart = has_next ? istart_ff[p1[IdxW-1:0]] : '0;
      nend   = has_next ? iend_ff[p1[IdxW-1:0]] : '0;
      win = {1'b0, cont_ff} + {17'd0, window_size};
      rej = !c_ff.len_ok || ({1'b0, c_ff.seg_end} >= win) || (c_ff.seq < pend)
            || (has_next && c_ff.seg_end > nstart);
      touch = has_next && (c_ff.seg_end == nstart);
      full = (c_ff.seq != pend) && !touch && (count_ff == CntW'(MaxIntervals));
      newend = touch ? nend : c_ff.seg_end;
      cs = (c_ff.seq < {1'b0, total_length}) ? c_ff.seq : {1'b0, total_length};
      ce = (c_ff.seg_end < {1'b0, total_length}) ? c_ff.seg_end
                                                  : {1'b0, total_length};
      two_to = {2'b0, timeout_ticks, 1'b0};
   end

   always_comb begin
      state_in = state_ff;
      c_in = c_ff;
      count_in = count_ff;
      cont_in = cont_ff;
      high_in = high_ff;
      idle_in = idle_ff;
      started_in = started_ff;
      ov_in = ov_ff;
      rsp_in = rsp_ff;
      for (int i = 0; i < MaxIntervals; i++) begin
         istart_in[i] = istart_ff[i];
         iend_in[i] = iend_ff[i];
      end
      if (ov_ff && out_ready) ov_in = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (cmd_valid && cmd_ready) begin
               c_in = cmd;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_LOAD;
            ov_in = 1'b1;
            rsp_in = '0;
            if (c_ff.idle) begin
               if (cont_ff != 32'd0 && idle_ff == 18'd0) begin
                  rsp_in.reply_kind = REPLY_ACK;
                  rsp_in.reply_seq = cont_ff;
               end else if (idle_ff > {2'b0, timeout_ticks}) begin
                  if (high_ff > cont_ff || {1'b0, idle_ff} > two_to) begin
                     rsp_in.reply_kind = REPLY_RESEND;
                     rsp_in.reply_seq = cont_ff;
                     idle_in = 18'd0;
                  end
               end
               if (started_ff && idle_in != IDLE_MAX) idle_in = idle_in + 18'd1;
            end else if (c_ff.data) begin
               started_in = 1'b1;
               if (c_ff.seq > high_ff) high_in = c_ff.seq;
               if (!rej && full) begin
                  rsp_in.status = STATUS_FAIL;
                  count_in = '0; cont_in = '0; high_in = '0;
                  idle_in = '0; started_in = 1'b0;
               end else if (!rej) begin
                  rsp_in.accepted = 1'b1;
                  rsp_in.copy_start = cs;
                  rsp_in.copy_end = ce;
                  idle_in = '0;
                  if (c_ff.seq == pend) begin
                     if (touch) begin
                        // close the gap: drop the next entry and shift down
                        for (int i = 0; i < MaxIntervals - 1; i++) begin
                           if (CntW'(i) >= p1) begin
                              istart_in[i] = istart_ff[i+1];
                              iend_in[i] = iend_ff[i+1];
                           end
                        end
                        count_in = count_ff - CntW'(1);
                     end
                     if (have_p) iend_in[p] = newend;
                     else cont_in = newend;
                  end else if (touch) begin
                     istart_in[p1[IdxW-1:0]] = c_ff.seq;
                  end else begin
                     // open a slot at p+1 by shifting up
                     for (int i = 1; i < MaxIntervals; i++) begin
                        if (CntW'(i) > p1) begin
                           istart_in[i] = istart_ff[i-1];
                           iend_in[i] = iend_ff[i-1];
                        end
                     end
                     istart_in[p1[IdxW-1:0]] = c_ff.seq;
                     iend_in[p1[IdxW-1:0]] = c_ff.seg_end;
                     count_in = count_ff + CntW'(1);
                  end
                  if (cont_in >= {1'b0, total_length}) begin
                     rsp_in.reply_kind = REPLY_ACK;
                     rsp_in.reply_seq = cont_in;
                     rsp_in.status = STATUS_DONE;
                     rsp_in.received_count = cont_in;
                     count_in = '0; cont_in = '0; high_in = '0;
                     idle_in = '0; started_in = 1'b0;
                  end
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign cmd_ready = (state_ff == ST_LOAD) && (!ov_ff || out_ready);
   assign out_valid = ov_ff;
   assign out_rsp = rsp_ff;

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      rsp_ff <= rsp_in;
      le_ff <= le_in;
      for (int i = 0; i < MaxIntervals; i++) begin
         istart_ff[i] <= istart_in[i];
         iend_ff[i] <= iend_in[i];
      end
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         cont_ff <= '0;
         high_ff <= '0;
         idle_ff <= '0;
         started_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cont_ff <= cont_in;
         high_ff <= high_in;
         idle_ff <= idle_in;
         started_ff <= started_in;
         ov_ff <= ov_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxIntervals)) else $error("interval count too large");
   a_exec_one: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> state_ff == ST_LOAD && ov_ff)
      else $error("exec did not produce a result");
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_rsp.status != STATUS_RUN && $rose(out_valid)) |->
      (count_ff == '0 && cont_ff == 32'd0)) else $error("state not cleared");

endmodule

>>> rtl/reliable_stream_receiver_core.sv
// top level of the reliable stream receiver
// path: an item passes the front-end queue, then the engine's load and execute steps, to rsp_valid
// the engine takes a new item only after the execute step of the last one has ended
// the load step registers the per-entry compares of the 16-entry interval table
// reset: synchronous, clears the queue, the transfer state and the registers
// to total_length 1, window_size 10000, timeout_ticks 100
module reliable_stream_receiver_core import rsr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [7:0]  req_magic,
   input  logic [7:0]  req_kind_bits,
   input  logic [15:0] req_seg_length,
   input  logic [31:0] req_seg_seq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_reply_kind,
   output logic [31:0] rsp_reply_seq,
   output logic        rsp_accepted,
   output logic [31:0] rsp_copy_start,
   output logic [31:0] rsp_copy_end,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_received_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   // configuration registers
   logic [30:0] total_length_ff;
   logic [15:0] window_size_ff;
   logic [15:0] timeout_ff;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd;
   rsp_type rsp;

   // writes are always taken; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff <= 31'd1;
         window_size_ff <= 16'd10000;
         timeout_ff <= 16'd100;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TOTAL_LENGTH: total_length_ff <= csr_data[30:0];
            CSR_WINDOW_SIZE:  window_size_ff <= csr_data[15:0];
            CSR_TIMEOUT:      timeout_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // front end classifies the header and checks the end offset
   rsr_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_mode, .req_magic,
      .req_kind_bits, .req_seg_length, .req_seg_seq,
      .cmd_valid, .cmd_ready, .cmd
   );

   // engine owns the interval table and the output register
   rsr_engine u_engine (
      .clock, .reset,
      .total_length(total_length_ff), .window_size(window_size_ff),
      .timeout_ticks(timeout_ff),
      .cmd_valid, .cmd_ready, .cmd,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_rsp(rsp)
   );

   assign rsp_reply_kind = rsp.reply_kind;
   assign rsp_reply_seq = rsp.reply_seq;
   assign rsp_accepted = rsp.accepted;
   assign rsp_copy_start = rsp.copy_start;
   assign rsp_copy_end = rsp.copy_end;
   assign rsp_status = rsp.status;
   assign rsp_received_count = rsp.received_count;

endmodule
